// File: sv/rid_pkg.sv
// ----------------------------------------------------------------------------
// rid_pkg: shared constants and helpers for the I/Q detector
// Register indexes, detector mode codes, log2 squaring step, output encoder.
// ----------------------------------------------------------------------------
package rid_pkg;

	localparam int OUT_W    = 48;
	localparam int LOGF     = 32;   // fraction bits of the log2 values
	localparam int SB_DEF   = 16;
	localparam int FRAC_DEF = 16;

	localparam logic [29:0]      LN2_Q30 = 30'd744261118;
	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic [1:0] MODE_ENV    = 2'd0;
	localparam logic [1:0] MODE_SQUARE = 2'd1;
	localparam logic [1:0] MODE_LOGSQ  = 2'd2;
	localparam logic [1:0] MODE_LOGMAG = 2'd3;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_GAIN  = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;

	// index of the highest set bit, 0 for zero
	function automatic logic [5:0] msb64(input logic [63:0] x);
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) r = 6'(i);
		end
		return r;
	endfunction

	// one fraction bit of log2: square the Q1.31 mantissa, renormalize
	// returns {fraction bit, new mantissa}
	function automatic logic [32:0] sq_step(input logic [31:0] m);
		logic [63:0] sq;
		logic [32:0] t;
		sq = 64'(m) * 64'(m);
		t  = sq[63:31];
		if (t[32]) begin
			return {1'b1, t[32:1]};
		end
		return {1'b0, t[31:0]};
	endfunction

	// sign and magnitude to saturated two's complement
	function automatic logic [OUT_W-1:0] encode(input logic neg, input logic [63:0] mag);
		logic [63:0] m;
		m = mag;
		if (neg) begin
			if (m > 64'(OUT_MIN)) m = 64'(OUT_MIN);
			return OUT_W'(~m + 64'd1);
		end
		if (m > 64'(OUT_MAX)) m = 64'(OUT_MAX);
		return OUT_W'(m);
	endfunction

endpackage

// File: sv/rid_log_cell.sv
// ----------------------------------------------------------------------------
// rid_log_cell: one pipeline cell of the detector core
// One log2 squaring step plus NSTEP restoring square-root steps, registered.
// ----------------------------------------------------------------------------
module rid_log_cell import rid_pkg::*; #(
	parameter int SB    = SB_DEF,
	parameter int FRAC  = FRAC_DEF,
	parameter int FIRST = 0,
	parameter int NSTEP = 2,
	parameter int XW    = 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [31:0]           m_i,
	input  logic [31:0]           frac_i,
	input  logic [SB+FRAC-1:0]    root_i,
	input  logic [SB+FRAC+1:0]    rem_i,
	input  logic [2*(SB+FRAC)-1:0] rad_i,
	input  logic [XW-1:0]         x_i,
	output logic [31:0]           m_o,
	output logic [31:0]           frac_o,
	output logic [SB+FRAC-1:0]    root_o,
	output logic [SB+FRAC+1:0]    rem_o,
	output logic [2*(SB+FRAC)-1:0] rad_o,
	output logic [XW-1:0]         x_o
);

	localparam int RW   = SB + FRAC;
	localparam int RADW = 2 * RW;

	logic [32:0]     sq;
	logic [RW-1:0]   root_n;
	logic [RW+1:0]   rem_n;
	logic [RW+1:0]   trial;
	logic [RADW-1:0] rad_n;

	always_comb begin
		sq     = sq_step(m_i);
		root_n = root_i;
		rem_n  = rem_i;
		rad_n  = rad_i;
		trial  = '0;
		for (int j = 0; j < NSTEP; j++) begin
			if (FIRST + j < RW) begin
				rem_n = {rem_n[RW-1:0], rad_n[RADW-1 -: 2]};
				rad_n = rad_n << 2;
				trial = {root_n, 2'b01};
				if (rem_n >= trial) begin
					rem_n  = rem_n - trial;
					root_n = {root_n[RW-2:0], 1'b1};
				end else begin
					root_n = {root_n[RW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_o    <= sq[31:0];
			frac_o <= {frac_i[30:0], sq[32]};
			root_o <= root_n;
			rem_o  <= rem_n;
			rad_o  <= rad_n;
			x_o    <= x_i;
		end
	end

endmodule

// File: sv/rid_scale_log2.sv
// ----------------------------------------------------------------------------
// rid_scale_log2: log2 of the scale register
// Iterative unit, one fraction bit per cycle, restarted by a scale write.
// ----------------------------------------------------------------------------
module rid_scale_log2 import rid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [15:0] scale,
	output logic        busy,
	output logic [35:0] l2s
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] m_q;
	logic [3:0]  e_q;
	logic [31:0] frac_q;
	logic [5:0]  e_ld;
	logic [47:0] nrm;
	logic [31:0] m_ld;
	logic [32:0] st;

	always_comb begin
		e_ld = msb64(64'(scale));
		nrm  = (48'(scale) << 31) >> e_ld;
		m_ld = nrm[31:0];
		st   = sq_step(m_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			m_q    <= '0;
			e_q    <= 4'd8;    // log2(1.0 in Q8.8)
			frac_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			m_q    <= m_ld;
			e_q    <= e_ld[3:0];
			frac_q <= '0;
		end else if (busy_q) begin
			m_q    <= st[31:0];
			frac_q <= {frac_q[30:0], st[32]};
			cnt_q  <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign l2s  = {e_q, frac_q};

endmodule

// File: sv/radar_iq_detector_unit.sv
// ----------------------------------------------------------------------------
// radar_iq_detector_unit: envelope / square-law / log detector for I/Q data
// Pipelined, one sample per clock unless stalled, Q(47-F).F saturated output.
// ----------------------------------------------------------------------------
//  channel | signals                              | beat
//  --------+--------------------------------------+--------------------------
//  in      | in_valid, in_ready, sample_i/q       | one complex sample
//  out     | out_valid, out_ready, detected,      | one detected value
//          | log_of_zero                          |
//  cfg     | cfg_we, cfg_addr, cfg_wdata          | one register write
//
// One beat enters per cycle while in_ready is high.
// The 32 log2 squaring cells set the depth; the square root rides along.
// A scale write runs a log2 of the scale; in_ready is low while it runs.
// A stall on out freezes the whole pipe; nothing is dropped or repeated.
// Reset clears valid bits and presets settings; data registers are not reset.
// ----------------------------------------------------------------------------
module radar_iq_detector_unit import rid_pkg::*; #(
	parameter int SAMPLE_BITS = SB_DEF,
	parameter int FRAC_BITS   = FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUT_W-1:0]       detected,
	output logic                          log_of_zero,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [15:0]                   cfg_wdata
);

	localparam int SB    = SAMPLE_BITS;
	localparam int RW    = SB + FRAC_BITS;         // root width
	localparam int RADW  = 2 * RW;                 // radicand width
	localparam int PW    = 2 * SB;                 // I^2+Q^2 width
	localparam int NCELL = LOGF;
	localparam int RPER  = (RW + NCELL - 1) / NCELL;
	localparam int XW    = OUT_W + 1 + 6;          // {e, zero, square det}
	localparam int NST   = NCELL + 7;
	localparam int SH0   = 38 - FRAC_BITS;
	localparam int SH1   = SH0 + 1;
	localparam logic [38:0] NEGC = 39'(16) << 32;  // 16.0 in Q.32

	// configuration
	logic [1:0]  mode_q;
	logic [15:0] gain_q;
	logic [15:0] scale_q;
	logic        busy;
	logic [35:0] l2s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SQUARE;
			gain_q  <= 16'd256;
			scale_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODE:  mode_q  <= cfg_wdata[1:0];
				REG_GAIN:  gain_q  <= cfg_wdata;
				REG_SCALE: scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rid_scale_log2 u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cfg_we && cfg_addr == REG_SCALE),
		.scale  (cfg_wdata),
		.busy   (busy),
		.l2s    (l2s)
	);

	// global advance: the output register is free or being emptied
	logic           adv;
	logic [NST-1:0] vld_q;

	assign adv       = !vld_q[NST-1] || out_ready;
	assign in_ready  = adv && !busy;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid && !busy};
		end
	end

	// s1: magnitudes
	logic [SB-1:0] si_u, sq_u;
	logic [SB-1:0] ai_s1, aq_s1;

	assign si_u = $unsigned(sample_i);
	assign sq_u = $unsigned(sample_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			ai_s1 <= si_u[SB-1] ? (~si_u + 1'b1) : si_u;
			aq_s1 <= sq_u[SB-1] ? (~sq_u + 1'b1) : sq_u;
		end
	end

	// s2: power
	logic [PW-1:0] p_s2;

	always_ff @(posedge clk) begin
		if (adv) p_s2 <= PW'(ai_s1) * PW'(ai_s1) + PW'(aq_s1) * PW'(aq_s1);
	end

	// s3: log2 normalize, square-law value, radicand
	logic [5:0]       e_n;
	logic [95:0]      nrm;
	logic [63:0]      sq_lim;
	logic [OUT_W-1:0] sqdet_n;
	logic [31:0]      m_s3;
	logic [RADW-1:0]  rad_s3;
	logic [XW-1:0]    x_s3;

	always_comb begin
		e_n     = msb64(64'(p_s2));
		nrm     = (96'(p_s2) << 31) >> e_n;
		sq_lim  = 64'(OUT_MAX) >> FRAC_BITS;
		sqdet_n = (64'(p_s2) > sq_lim) ? OUT_MAX : OUT_W'(64'(p_s2) << FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3   <= nrm[31:0];
			rad_s3 <= RADW'(p_s2) << (2 * FRAC_BITS);
			x_s3   <= {e_n, p_s2 == '0, sqdet_n};
		end
	end

	// cells: one log2 bit and RPER root bits each
	logic [31:0]     m_w    [0:NCELL];
	logic [31:0]     frac_w [0:NCELL];
	logic [RW-1:0]   root_w [0:NCELL];
	logic [RW+1:0]   rem_w  [0:NCELL];
	logic [RADW-1:0] rad_w  [0:NCELL];
	logic [XW-1:0]   x_w    [0:NCELL];

	assign m_w[0]    = m_s3;
	assign frac_w[0] = '0;
	assign root_w[0] = '0;
	assign rem_w[0]  = '0;
	assign rad_w[0]  = rad_s3;
	assign x_w[0]    = x_s3;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		rid_log_cell #(
			.SB    (SB),
			.FRAC  (FRAC_BITS),
			.FIRST (k * RPER),
			.NSTEP (RPER),
			.XW    (XW)
		) u_cell (
			.clk    (clk),
			.en     (adv),
			.m_i    (m_w[k]),
			.frac_i (frac_w[k]),
			.root_i (root_w[k]),
			.rem_i  (rem_w[k]),
			.rad_i  (rad_w[k]),
			.x_i    (x_w[k]),
			.m_o    (m_w[k+1]),
			.frac_o (frac_w[k+1]),
			.root_o (root_w[k+1]),
			.rem_o  (rem_w[k+1]),
			.rad_o  (rad_w[k+1]),
			.x_o    (x_w[k+1])
		);
	end

	// a: total log2 offset by 16.0, to sign and magnitude; non-log value
	logic [XW-1:0]    xf;
	logic [38:0]      pos;
	logic [38:0]      mag_a;
	logic             neg_a, zero_a;
	logic [OUT_W-1:0] nl_a;

	assign xf  = x_w[NCELL];
	assign pos = 39'({l2s, 1'b0}) + 39'({xf[XW-1 -: 6], frac_w[NCELL]});

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_a  <= pos < NEGC;
			mag_a  <= (pos < NEGC) ? (NEGC - pos) : (pos - NEGC);
			zero_a <= xf[OUT_W];
			nl_a   <= (mode_q == MODE_ENV) ? encode(1'b0, 64'(root_w[NCELL]))
			                               : xf[OUT_W-1:0];
		end
	end

	// b: times ln2
	logic [60:0]      lnp;
	logic [36:0]      lnm_b;
	logic             neg_b, zero_b;
	logic [OUT_W-1:0] nl_b;

	assign lnp = 61'(mag_a[38:8]) * 61'(LN2_Q30);

	always_ff @(posedge clk) begin
		if (adv) begin
			lnm_b  <= lnp[60:24];
			neg_b  <= neg_a;
			zero_b <= zero_a;
			nl_b   <= nl_a;
		end
	end

	// c: times |gain|
	logic [15:0]      amag;
	logic [52:0]      prod_c;
	logic             neg_c, zero_c;
	logic [OUT_W-1:0] nl_c;

	assign amag = gain_q[15] ? 16'(17'h10000 - 17'(gain_q)) : gain_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_c <= 53'(lnm_b) * 53'(amag);
			neg_c  <= neg_b ^ gain_q[15];
			zero_c <= zero_b;
			nl_c   <= nl_b;
		end
	end

	// d: round half away, saturate, select by mode
	logic [53:0]      r0, r1, r;
	logic             is_log;
	logic [OUT_W-1:0] det_n;
	logic             flag_n;
	logic [OUT_W-1:0] det_q;
	logic             flag_q;

	always_comb begin
		r0     = (54'(prod_c) + (54'(1) << (SH0 - 1))) >> SH0;
		r1     = (54'(prod_c) + (54'(1) << (SH1 - 1))) >> SH1;
		r      = (mode_q == MODE_LOGMAG) ? r1 : r0;
		is_log = (mode_q == MODE_LOGSQ) || (mode_q == MODE_LOGMAG);
		if (!is_log) begin
			det_n  = nl_c;
			flag_n = 1'b0;
		end else if (zero_c || scale_q == '0) begin
			det_n  = OUT_MIN;
			flag_n = 1'b1;
		end else begin
			det_n  = encode(neg_c && r != '0, 64'(r));
			flag_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_q  <= det_n;
			flag_q <= flag_n;
		end
	end

	assign detected    = $signed(det_q);
	assign log_of_zero = flag_q;

`ifndef ASSERT_OFF
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("input taken while scale log2 runs");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input taken while pipe is stalled");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && log_of_zero |-> det_q == OUT_MIN)
		else $error("log of zero flag without minimum value");

	a_zero_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode_q == MODE_ENV || mode_q == MODE_SQUARE) |-> !log_of_zero)
		else $error("log of zero flag in a linear mode");
`endif

endmodule

// File: verif/tb_radar_iq_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_radar_iq_detector_unit: self-checking bench for the I/Q detector
// A directed table (mode extremes, log of zero, saturation) is followed by
// random samples under changing settings and random idling on both channels.
// Each detected beat is checked against a typed answer or the in-bench predictor.
// ----------------------------------------------------------------------------
module tb_radar_iq_detector_unit import rid_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_NONE = 2'd3;   // unmapped index, write is dropped
	localparam int DRAIN_CYCLES = 50;         // pipe depth is 39

	typedef struct packed {
		logic [OUT_W-1:0] det;
		logic             zero;
	} detection_t;

	// one directed row: a register write or a sample, optionally with a typed answer
	typedef struct packed {
		logic             is_cfg;
		logic [1:0]       addr;
		logic [15:0]      a;      // write data, or sample_i
		logic [15:0]      b;      // sample_q
		logic             typed;
		logic [OUT_W-1:0] det;
		logic             zero;
	} row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [15:0]      sample_i = '0;
	logic signed [15:0]      sample_q = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [OUT_W-1:0] detected;
	logic                    log_of_zero;
	logic                    cfg_we = 1'b0;
	logic [1:0]              cfg_addr = '0;
	logic [15:0]             cfg_wdata = '0;

	// shadow of the block's registers
	logic [1:0]  mode_sh;
	logic [15:0] gain_sh;
	logic [15:0] scale_sh;

	detection_t  pending_q[$];
	int          errors = 0;
	int          snd_idle = 0;
	int          rcv_idle = 0;

	always #2 clk = ~clk;

	radar_iq_detector_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_i(sample_i), .sample_q(sample_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.detected(detected), .log_of_zero(log_of_zero),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// log2 in Q.32: msb position, then 32 truncating squaring steps
	function automatic logic [63:0] log2_fix(input logic [63:0] x);
		int unsigned e;
		logic [63:0] m, fr;
		e = 0;
		while (e < 63 && (x >> (e + 1)) != 0) e++;
		m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
		fr = '0;
		for (int k = 0; k < 32; k++) begin
			m = (m * m) >> 31;
			fr = fr << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				fr[0] = 1'b1;
			end
		end
		return (64'(e) << 32) | fr;
	endfunction

	// bitwise square root of P with 16 extra fraction bits
	function automatic logic [63:0] root_fix(input logic [63:0] p);
		logic [63:0] rem, root, trial, pair;
		rem = '0;
		root = '0;
		for (int k = 0; k < 40; k++) begin
			pair = (k < 24) ? ((p >> (2 * (23 - k))) & 64'd3) : 64'd0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic [OUT_W-1:0] sat_word(input logic neg, input logic [63:0] mag);
		if (neg) begin
			if (mag > 64'(OUT_MIN)) mag = 64'(OUT_MIN);
			return OUT_W'(~mag + 64'd1);
		end
		if (mag > 64'(OUT_MAX)) mag = 64'(OUT_MAX);
		return OUT_W'(mag);
	endfunction

	function automatic detection_t detect(input logic [15:0] si, input logic [15:0] sq);
		detection_t  d;
		logic [63:0] ai, aq, p, pos, negc, m, lnm, amag, r;
		logic        neg;
		int unsigned sh;
		ai = si[15] ? 64'(17'h10000 - 17'(si)) : 64'(si);
		aq = sq[15] ? 64'(17'h10000 - 17'(sq)) : 64'(sq);
		p = ai * ai + aq * aq;
		d.zero = 1'b0;
		case (mode_sh)
			MODE_ENV: d.det = sat_word(1'b0, root_fix(p));
			MODE_SQUARE: d.det = (p > (64'(OUT_MAX) >> 16)) ? OUT_MAX : OUT_W'(p << 16);
			default: begin
				if (scale_sh == 0 || p == 0) begin
					d.det = OUT_MIN;
					d.zero = 1'b1;
				end else begin
					pos = 2 * log2_fix(64'(scale_sh)) + log2_fix(p);
					negc = 64'd16 << 32;
					sh = (mode_sh == MODE_LOGMAG) ? 23 : 22;
					neg = (pos < negc);
					m = neg ? (negc - pos) : (pos - negc);
					lnm = ((m >> 8) * 64'(LN2_Q30)) >> 24;
					if (gain_sh[15]) begin
						amag = 64'(17'h10000 - 17'(gain_sh));
						neg = !neg;
					end else begin
						amag = 64'(gain_sh);
					end
					r = (lnm * amag + (64'd1 << (sh - 1))) >> sh;
					if (r == 0) neg = 1'b0;
					d.det = sat_word(neg, r);
				end
			end
		endcase
		return d;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// --- checker: every detected beat against the oldest prediction ---
	always @(posedge clk) begin
		detection_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				report("unexpected beat", 64'(detected), 64'd0);
			end else begin
				w = pending_q.pop_front();
				if (detected !== w.det) report("detected", 64'(detected), 64'(w.det));
				if (log_of_zero !== w.zero) report("log_of_zero", 64'(log_of_zero), 64'(w.zero));
			end
		end
	end

	// --- receiver: random back-pressure ---
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= rcv_idle);
	end

	// quiet pipe, plus margin for a beat that is still in flight
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_MODE: mode_sh = val[1:0];
			REG_GAIN: gain_sh = val;
			REG_SCALE: scale_sh = val;
			default: ;
		endcase
	endtask

	// one input beat; valid stays up across back-to-back beats
	task automatic send(input logic [15:0] si, input logic [15:0] sq,
			input logic typed, input detection_t want);
		while ($urandom_range(99) < snd_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample_i = si;
		sample_q = sq;
		do @(posedge clk); while (!in_ready);
		pending_q.insert(pending_q.size(), typed ? want : detect(si, sq));
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_sample();
		logic [15:0] pick[5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
		case ($urandom_range(9))
			0: return pick[$urandom_range(4)];
			1, 2: return 16'($signed($urandom_range(16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0100;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_scale();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(8));
			default: return 16'($urandom);
		endcase
	endfunction

	// --- timeout ---
	initial begin
		#400us;
		$display("Some tests failed");
		$finish;
	end

	// --- stimulus ---
	initial begin
		row_t rows[22];
		detection_t none;
		none = '0;
		rows = '{
			// reset settings: square law
			'{1'b0, REG_MODE, 16'h0000, 16'h0000, 1'b1, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h0001, 16'h0000, 1'b1, 48'd65536, 1'b0},
			'{1'b0, REG_MODE, 16'h8000, 16'h8000, 1'b1, OUT_MAX, 1'b0},
			'{1'b0, REG_MODE, 16'h7FFF, 16'h8000, 1'b0, 48'd0, 1'b0},
			// envelope
			'{1'b1, REG_MODE, 16'(MODE_ENV), 16'h0, 1'b0, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h0003, 16'hFFFC, 1'b1, 48'd327680, 1'b0},
			'{1'b0, REG_MODE, 16'h8000, 16'h8000, 1'b0, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h0000, 16'h0000, 1'b1, 48'd0, 1'b0},
			// log of magnitude at unit gain and scale
			'{1'b1, REG_MODE, 16'(MODE_LOGMAG), 16'h0, 1'b0, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h0000, 16'h0000, 1'b1, OUT_MIN, 1'b1},
			'{1'b0, REG_MODE, 16'h0001, 16'h0000, 1'b1, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h7FFF, 16'h8000, 1'b0, 48'd0, 1'b0},
			// unmapped index must not disturb anything
			'{1'b1, REG_NONE, 16'hFFFF, 16'h0, 1'b0, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h0000, 16'hFFFF, 1'b1, 48'd0, 1'b0},
			// log of square, most negative gain
			'{1'b1, REG_MODE, 16'(MODE_LOGSQ), 16'h0, 1'b0, 48'd0, 1'b0},
			'{1'b1, REG_GAIN, 16'h8000, 16'h0, 1'b0, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h0007, 16'hFFFF, 1'b0, 48'd0, 1'b0},
			// zero scale flags regardless of the sample
			'{1'b1, REG_SCALE, 16'h0000, 16'h0, 1'b0, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h0005, 16'h0005, 1'b1, OUT_MIN, 1'b1},
			// largest scale and gain
			'{1'b1, REG_SCALE, 16'hFFFF, 16'h0, 1'b0, 48'd0, 1'b0},
			'{1'b1, REG_GAIN, 16'h7FFF, 16'h0, 1'b0, 48'd0, 1'b0},
			'{1'b0, REG_MODE, 16'h8000, 16'h8000, 1'b0, 48'd0, 1'b0}
		};

		mode_sh = MODE_SQUARE;
		gain_sh = 16'h0100;
		scale_sh = 16'h0100;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, no idling on the sender
		foreach (rows[n]) begin
			if (rows[n].is_cfg) begin
				wait_idle();
				write_reg(rows[n].addr, rows[n].a);
			end else begin
				send(rows[n].a, rows[n].b, rows[n].typed, detection_t'({rows[n].det, rows[n].zero}));
			end
		end

		// random part in three idling phases, settings changed between bursts
		for (int ph = 0; ph < 3; ph++) begin
			wait_idle();   // sender holds off until the pipe is empty
			snd_idle = (ph == 0) ? 36 : (ph == 1) ? 76 : 0;
			rcv_idle = (ph == 0) ? 76 : (ph == 1) ? 36 : 0;
			for (int burst = 0; burst < 6; burst++) begin
				wait_idle();
				write_reg(REG_MODE, 16'($urandom_range(3)));
				write_reg(REG_GAIN, rand_gain());
				write_reg(REG_SCALE, rand_scale());
				for (int k = 0; k < 31; k++) send(rand_sample(), rand_sample(), 1'b0, none);
			end
		end
		in_valid = 1'b0;

		while (pending_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: radar_iq_detector_unit.f
sv/rid_pkg.sv
sv/rid_log_cell.sv
sv/rid_scale_log2.sv
sv/radar_iq_detector_unit.sv
verif/tb_radar_iq_detector_unit.sv
